// ===== design/pncs_pkg.sv =====
package pncs_pkg;

    // operation codes of an input item
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // only the upper six bits of each component ever reach a distance
    localparam int unsigned COMP_W  = 6;
    localparam int unsigned ENTRY_W = 3 * COMP_W;
    localparam int unsigned DIST_W  = 16;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [DIST_W-1:0]  dist_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start_search;
        logic wr_en;
        logic rd_en;
        logic out_load;
        logic out_search;
    } pncs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
    } pncs_stat_t;

    // saturate a search component to 255, keep bits 7..2
    function automatic logic [COMP_W-1:0] pncs_sat(input logic [9:0] v);
        logic [COMP_W-1:0] res;
        res = (|v[9:8]) ? {COMP_W{1'b1}} : v[7:2];
        return res;
    endfunction

    // weighted distance 3*dr^2 + 6*dg^2 + 2*db^2 on the truncated components
    function automatic dist_t pncs_dist(input entry_t a, input entry_t b);
        logic [COMP_W-1:0]   dr;
        logic [COMP_W-1:0]   dg;
        logic [COMP_W-1:0]   db;
        logic [2*COMP_W-1:0] sr;
        logic [2*COMP_W-1:0] sg;
        logic [2*COMP_W-1:0] sb;
        dr = (a[17:12] > b[17:12]) ? (a[17:12] - b[17:12]) : (b[17:12] - a[17:12]);
        dg = (a[11:6] > b[11:6]) ? (a[11:6] - b[11:6]) : (b[11:6] - a[11:6]);
        db = (a[5:0] > b[5:0]) ? (a[5:0] - b[5:0]) : (b[5:0] - a[5:0]);
        sr = (2*COMP_W)'(dr) * (2*COMP_W)'(dr);
        sg = (2*COMP_W)'(dg) * (2*COMP_W)'(dg);
        sb = (2*COMP_W)'(db) * (2*COMP_W)'(db);
        return DIST_W'(DIST_W'(sr) * DIST_W'(3))
             + DIST_W'(DIST_W'(sg) * DIST_W'(6))
             + DIST_W'(DIST_W'(sb) * DIST_W'(2));
    endfunction

endpackage

// ===== design/pncs_ctrl.sv =====
module pncs_ctrl
    import pncs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       opcode,
    input  logic       out_ready,
    input  pncs_stat_t stat,
    output logic       in_ready,
    output logic       out_valid,
    output pncs_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       search_reg;
    logic       search_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        search_next    = search_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.out_search = search_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    search_next = (opcode == OP_SEARCH);
                    if (opcode == OP_SEARCH)
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            search_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/pncs_dpath.sv =====
module pncs_dpath
    import pncs_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  pncs_cmd_t  cmd,
    input  logic [7:0] entry_index,
    input  logic [9:0] red,
    input  logic [9:0] green,
    input  logic [9:0] blue,
    output pncs_stat_t stat,
    output logic [7:0] nearest_index
);

    localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);

    entry_t             mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;

    logic [IDX_W-1:0] rd_addr_reg;
    entry_t           rd_data_reg;
    logic             rd_vld_reg;
    logic             cmp_en_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    entry_t           key_reg;
    dist_t            best_dist_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [7:0]       echo_reg;
    logic [7:0]       result_reg;

    logic             wr_in_range;
    logic [IDX_W-1:0] wr_addr;
    entry_t           cmp_entry;
    dist_t            cmp_dist;

    assign wr_in_range    = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign wr_addr        = entry_index[IDX_W-1:0];
    assign stat.scan_last = (rd_addr_reg == IDX_W'(PALETTE_ENTRIES - 1));

    // entries never written read as zero
    assign cmp_entry = rd_vld_reg ? rd_data_reg : '0;
    assign cmp_dist  = pncs_dist(cmp_entry, key_reg);

    assign nearest_index = result_reg;

    // palette store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[wr_addr] <= {red[7:2], green[7:2], blue[7:2]};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            cmp_en_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (cmd.wr_en && wr_in_range)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            cmp_en_reg <= cmd.rd_en;
            if (cmd.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr_reg];
            end
            priority if (cmd.start_search)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                rd_addr_reg <= rd_addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            cmp_idx_reg <= rd_addr_reg;
        end
        if (cmd.wr_en)
        begin
            echo_reg <= entry_index;
        end
        priority if (cmd.start_search)
        begin
            key_reg       <= {pncs_sat(red), pncs_sat(green), pncs_sat(blue)};
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end
        else if (cmp_en_reg && (cmp_dist < best_dist_reg))
        begin
            best_dist_reg <= cmp_dist;
            best_idx_reg  <= cmp_idx_reg;
        end
        if (cmd.out_load)
        begin
            result_reg <= cmd.out_search ? 8'(best_idx_reg) : echo_reg;
        end
    end

endmodule

// ===== design/palette_nearest_color_search_core.sv =====
// nearest palette color search: holds PALETTE_ENTRIES colors, all zero after
// reset. opcode write stores bits 7..2 of red, green and blue at entry_index
// (ignored when entry_index >= PALETTE_ENTRIES) and returns entry_index.
// opcode search saturates each component to 255, drops its two low bits and
// returns the lowest index whose entry minimizes 3*dr^2 + 6*dg^2 + 2*db^2.
// every accepted item yields exactly one result transfer. a write item
// goes from idle to the finish state; a search item runs through the scan
// and drain states first; the scan reads the palette store through its
// single read port, one entry per cycle. a new item is accepted while the
// previous result still waits in the output register.
module palette_nearest_color_search_core
    import pncs_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] entry_index,
    input  logic [9:0] red,
    input  logic [9:0] green,
    input  logic [9:0] blue,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] nearest_index
);

    // command and status between sequencer and datapath
    pncs_cmd_t  cmd;
    pncs_stat_t stat;

    // sequencer: idle, scan, drain of the compare stage, result hand-off
    pncs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // palette store, distance unit, running minimum and output register
    pncs_dpath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .stat          (stat),
        .nearest_index (nearest_index)
    );

endmodule

// ===== design/pncs_checker.sv =====
module pncs_checker
    import pncs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       opcode,
    input logic [7:0] entry_index,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] nearest_index
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nearest_index))
        else $error("result changed while stalled");

    // one item at a time: ready drops after every transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after input transfer");

    // a write into a free output echoes its index through the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_WRITE) && !out_valid
        |-> ##2 (out_valid && (nearest_index == $past(entry_index, 2))))
        else $error("write echo missing or wrong");

endmodule

bind palette_nearest_color_search_core pncs_checker u_pncs_checker (.*);

// ===== bench/nearest_index_checker.sv =====
`timescale 1ns / 1ps

module nearest_index_checker
    import pncs_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] entry_index,
    input  logic [9:0] red,
    input  logic [9:0] green,
    input  logic [9:0] blue,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] nearest_index,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic       op;
        logic [7:0] index;
    } index_want_t;

    logic [23:0] palette_model [256];
    index_want_t index_q [$];
    int          err_total = 0;

    assign mismatches = err_total;

    task automatic report_error(input string msg);
        if (err_total < 100)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        err_total++;
    endtask

    // search component: clip at 255, keep bits 7..2
    function automatic int unsigned clip_component(input logic [9:0] v);
        int unsigned c;
        if (v > 10'd255)
        begin
            c = 255;
        end
        else
        begin
            c = 32'(v);
        end
        return c & 32'hFC;
    endfunction

    function automatic logic [7:0] nearest_entry(input logic [9:0] r, input logic [9:0] g,
                                                 input logic [9:0] b);
        int unsigned qr;
        int unsigned qg;
        int unsigned qb;
        int unsigned er;
        int unsigned eg;
        int unsigned eb;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned wdist;
        int unsigned best_dist;
        int unsigned best;
        qr = clip_component(r);
        qg = clip_component(g);
        qb = clip_component(b);
        best = 0;
        best_dist = 32'hFFFF_FFFF;
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            er = palette_model[i][23:16] & 8'hFC;
            eg = palette_model[i][15:8] & 8'hFC;
            eb = palette_model[i][7:0] & 8'hFC;
            dr = (er > qr) ? (er - qr) : (qr - er);
            dg = (eg > qg) ? (eg - qg) : (qg - eg);
            db = (eb > qb) ? (eb - qb) : (qb - eb);
            wdist = 3 * dr * dr + 6 * dg * dg + 2 * db * db;
            // strict compare keeps the lowest index on a tie
            if (wdist < best_dist)
            begin
                best_dist = wdist;
                best = i;
            end
        end
        return 8'(best);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        index_want_t head;
        index_want_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
            begin
                palette_model[i] = '0;
            end
            index_q.delete();
            outstanding = 0;
        end
        else
        begin
            // result transfer first: it always belongs to an older item
            if (out_valid && out_ready)
            begin
                if (index_q.size() == 0)
                begin
                    report_error($sformatf("result %0d with nothing outstanding",
                                           nearest_index));
                end
                else
                begin
                    head = index_q.pop_front();
                    if (nearest_index !== head.index)
                    begin
                        report_error($sformatf("%s: nearest_index expected %0d, got %0d",
                                               (head.op == OP_SEARCH) ? "search" : "write",
                                               head.index, nearest_index));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                fresh.op = opcode;
                if (opcode == OP_WRITE)
                begin
                    fresh.index = entry_index;
                    if (entry_index < PALETTE_ENTRIES)
                    begin
                        palette_model[entry_index] = {red[7:0], green[7:0], blue[7:0]};
                    end
                end
                else
                begin
                    fresh.index = nearest_entry(red, green, blue);
                end
                index_q.push_back(fresh);
            end
            outstanding = index_q.size();
        end
    end

endmodule

// ===== bench/palette_nearest_color_search_core_tb.sv =====
`timescale 1ns / 1ps

module palette_nearest_color_search_core_tb;

    import pncs_pkg::*;

    localparam int unsigned PALETTE_SIZE = 256;
    // watchdog limit on the total run length
    localparam int          CYCLE_LIMIT  = 2_500_000;
    localparam int          ITEMS_PER_PHASE = 450;

    typedef struct packed {
        logic       op;
        logic [7:0] idx;
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } color_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = OP_WRITE;
    logic [7:0] entry_index = '0;
    logic [9:0] red = '0;
    logic [9:0] green = '0;
    logic [9:0] blue = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] nearest_index;

    int mismatches;
    int outstanding;

    // idle percentages per phase: none, sender only, receiver only, both
    int send_pct [4]  = '{0, 71, 0, 22};
    int stall_pct [4] = '{0, 0, 71, 22};
    int send_idle  = 0;
    int recv_stall = 0;

    logic pressure_go = 1'b0;
    logic hold_off    = 1'b0;
    int   cycle_count = 0;

    // colors as sent by write items, used only to aim searches at the palette
    logic [29:0] written_color [256] = '{default: '0};

    palette_nearest_color_search_core #(
        .PALETTE_ENTRIES (PALETTE_SIZE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .nearest_index (nearest_index)
    );

    nearest_index_checker #(
        .PALETTE_ENTRIES (PALETTE_SIZE)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .nearest_index (nearest_index),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, forced low during the hold-off
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // long receiver hold-off while the sender keeps offering, so the
    // output register and the working item back up and in_ready drops
    initial
    begin
        wait (pressure_go);
        repeat (40) @(posedge clk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
    end

    // random idle cycles first, then offer the item until its transfer
    task automatic send_item(input color_item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.op;
        entry_index <= it.idx;
        red         <= it.r;
        green       <= it.g;
        blue        <= it.b;
        if (it.op == OP_WRITE)
        begin
            written_color[it.idx] = {it.r, it.g, it.b};
        end
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic op, input logic [7:0] idx, input logic [9:0] r,
                               input logic [9:0] g, input logic [9:0] b);
        color_item_t it;
        it.op  = op;
        it.idx = idx;
        it.r   = r;
        it.g   = g;
        it.b   = b;
        send_item(it);
    endtask

    // component a little off a known one, so searches land near palette colors
    function automatic logic [9:0] near_value(input logic [9:0] v);
        int x;
        x = int'(v) + int'($urandom_range(0, 24)) - 12;
        if (x < 0)
        begin
            x = 0;
        end
        if (x > 1023)
        begin
            x = 1023;
        end
        return 10'(x);
    endfunction

    function automatic color_item_t make_random_item();
        color_item_t it;
        logic [29:0] base;
        int          kind;
        it.idx = 8'($urandom_range(0, 255));
        // low entries get rewritten often, so aim there half of the time
        if ($urandom_range(0, 1) == 0)
        begin
            base = written_color[$urandom_range(0, 15)];
        end
        else
        begin
            base = written_color[$urandom_range(0, 255)];
        end
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 48)
        begin
            it.op = OP_WRITE;
            if ($urandom_range(0, 3) == 0)
            begin
                it.idx = 8'($urandom_range(0, 15));
            end
            case (kind)
                0:
                begin
                    // all-white entry
                    it.r = 10'd255;
                    it.g = 10'd255;
                    it.b = 10'd255;
                end
                1:
                begin
                    // duplicate color, makes ties
                    {it.r, it.g, it.b} = base;
                end
                2, 3:
                begin
                    // upper bits are dropped by the store
                    it.r = 10'($urandom);
                    it.g = 10'($urandom);
                    it.b = 10'($urandom);
                end
                default:
                begin
                    it.r = 10'($urandom_range(0, 255));
                    it.g = 10'($urandom_range(0, 255));
                    it.b = 10'($urandom_range(0, 255));
                end
            endcase
        end
        else
        begin
            it.op = OP_SEARCH;
            case (kind)
                0, 1:
                begin
                    {it.r, it.g, it.b} = base;
                end
                2, 3, 4, 5:
                begin
                    it.r = near_value(base[29:20]);
                    it.g = near_value(base[19:10]);
                    it.b = near_value(base[9:0]);
                end
                6, 7:
                begin
                    // saturation path
                    it.r = 10'($urandom);
                    it.g = 10'($urandom);
                    it.b = 10'($urandom);
                end
                default:
                begin
                    it.r = 10'($urandom_range(0, 255));
                    it.g = 10'($urandom_range(0, 255));
                    it.b = 10'($urandom_range(0, 255));
                end
            endcase
        end
        return it;
    endfunction

    initial
    begin
        color_item_t it;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared palette: every entry ties at zero, lowest index wins
        send_fields(OP_SEARCH, 8'h00, 10'd0, 10'd0, 10'd0);
        send_fields(OP_SEARCH, 8'hFF, 10'h3FF, 10'h3FF, 10'h3FF);
        // all-white write at the top entry, then saturated searches find it
        send_fields(OP_WRITE, 8'hFF, 10'd255, 10'd255, 10'd255);
        send_fields(OP_SEARCH, 8'h00, 10'h3FF, 10'h3FF, 10'h3FF);
        send_fields(OP_SEARCH, 8'h12, 10'd300, 10'd256, 10'd1000);
        send_fields(OP_SEARCH, 8'h00, 10'd252, 10'd253, 10'd254);
        // wide components: only bits 7..2 are stored
        send_fields(OP_WRITE, 8'h00, 10'h3FF, 10'h2AB, 10'h155);
        send_fields(OP_SEARCH, 8'h00, 10'h0FF, 10'h0AB, 10'h055);
        // same color after dropping the low bits at entries 0, 1 and 2: tie
        send_fields(OP_WRITE, 8'h01, 10'h0FF, 10'h0AB, 10'h055);
        send_fields(OP_WRITE, 8'h02, 10'h0FC, 10'h0A8, 10'h054);
        send_fields(OP_SEARCH, 8'hAA, 10'h0FE, 10'h0AA, 10'h056);
        send_fields(OP_WRITE, 8'h80, 10'h080, 10'h040, 10'h020);
        send_fields(OP_SEARCH, 8'h55, 10'h083, 10'h043, 10'h023);
        send_fields(OP_SEARCH, 8'h00, 10'h07C, 10'h044, 10'h01C);
        // first untouched zero entry is now index 3
        send_fields(OP_SEARCH, 8'h00, 10'd0, 10'd3, 10'd0);
        send_fields(OP_WRITE, 8'h00, 10'd0, 10'd0, 10'd0);
        send_fields(OP_SEARCH, 8'h00, 10'd1, 10'd2, 10'd3);
        // single channel differences weigh green heaviest
        send_fields(OP_WRITE, 8'h10, 10'd120, 10'd100, 10'd100);
        send_fields(OP_WRITE, 8'h11, 10'd100, 10'd120, 10'd100);
        send_fields(OP_WRITE, 8'h12, 10'd100, 10'd100, 10'd120);
        send_fields(OP_SEARCH, 8'h00, 10'd100, 10'd100, 10'd100);
        send_fields(OP_SEARCH, 8'h00, 10'd112, 10'd112, 10'd112);

        for (int p = 0; p < 4; p++)
        begin
            send_idle = send_pct[p];
            recv_stall <= stall_pct[p];
            if (p == 0)
            begin
                pressure_go <= 1'b1;
            end
            repeat (ITEMS_PER_PHASE)
            begin
                it = make_random_item();
                send_item(it);
            end
        end
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/pncs_pkg.sv
design/pncs_ctrl.sv
design/pncs_dpath.sv
design/palette_nearest_color_search_core.sv
design/pncs_checker.sv
bench/nearest_index_checker.sv
bench/palette_nearest_color_search_core_tb.sv
